>>> rtl/opcua_ms_pkg.sv
// ----------------------------------------------------------------------------
// OPC UA message splitter package
// Shared codes, header phases and the message type check.
// ----------------------------------------------------------------------------
package opcua_ms_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_CONTINUE = 3'd0,
      ST_SEARCH   = 3'd1,
      ST_FLUSH    = 3'd2,
      ST_ABORT    = 3'd3,
      ST_DROPPED  = 3'd4
   } status_type;

   typedef logic [3:0] phase_type;

   // header parser phases
   localparam phase_type PHASE_TYPE1 = 4'd0;
   localparam phase_type PHASE_TYPE2 = 4'd1;
   localparam phase_type PHASE_TYPE3 = 4'd2;
   localparam phase_type PHASE_FINAL = 4'd3;
   localparam phase_type PHASE_SIZE1 = 4'd4;
   localparam phase_type PHASE_SIZE2 = 4'd5;
   localparam phase_type PHASE_SIZE3 = 4'd6;
   localparam phase_type PHASE_SIZE4 = 4'd7;
   localparam phase_type PHASE_FLUSH = 4'd8;

   localparam int unsigned NUM_DIRS = 2;

   localparam logic [31:0] THRESHOLD_RESET = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam logic REG_LARGE_SIZE_THRESHOLD = 1'b0;

   // known message types, first byte in the top bits
   localparam logic [23:0] TYPE_HEL = {8'h48, 8'h45, 8'h4C};
   localparam logic [23:0] TYPE_ACK = {8'h41, 8'h43, 8'h4B};
   localparam logic [23:0] TYPE_ERR = {8'h45, 8'h52, 8'h52};
   localparam logic [23:0] TYPE_RHE = {8'h52, 8'h48, 8'h45};
   localparam logic [23:0] TYPE_OPN = {8'h4F, 8'h50, 8'h4E};
   localparam logic [23:0] TYPE_MSG = {8'h4D, 8'h53, 8'h47};
   localparam logic [23:0] TYPE_CLO = {8'h43, 8'h4C, 8'h4F};

   function automatic logic type_known(input logic [23:0] t);
      return (t == TYPE_HEL) || (t == TYPE_ACK) || (t == TYPE_ERR) ||
             (t == TYPE_RHE) || (t == TYPE_OPN) || (t == TYPE_MSG) ||
             (t == TYPE_CLO);
   endfunction

endpackage

>>> rtl/opcua_message_splitter.sv
// ----------------------------------------------------------------------------
// OPC UA message splitter
// Per-direction TCP header parser that reports flush points over a stream.
// ----------------------------------------------------------------------------
//
//  channel | role          | handshake            | payload
//  --------+---------------+----------------------+------------------------------
//  req_    | stream in     | tvalid/tready        | tdata: data_byte, segment_length
//          |               |                      | tuser: direction
//  rsp_    | stream out    | tvalid/tready        | tdata: flush_point, events
//          |               |                      | tuser: status
//  csr_    | register port | psel/penable, pready | large_size_threshold at 0x0
//
// One word is taken per cycle unless rsp_ stalls. The input register holds
// the word, and the parser state is read and updated in the cycle it moves
// into the output register. Throughput is one word per cycle, bound by the
// single update of the shared per-direction state.
// A stall on rsp_ holds both registers; req_tready drops only while both are full.
// Synchronous reset clears both parsers and the position tracking, and sets the
// threshold to all ones.

module opcua_message_splitter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] segment_length
   input  logic [1:0]  req_tuser,   // [1:0] direction

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] flush_point, [32] large_size_event,
                                    // [33] bad_type_event, [34] split_event,
                                    // [35] pipelined_event, [39:36] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [31:0] threshold_ff;
   logic        csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == opcua_ms_pkg::REG_LARGE_SIZE_THRESHOLD);
   assign csr_prdata = csr_hit ? threshold_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= opcua_ms_pkg::THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         threshold_ff <= csr_pwdata;
      end
   end

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_seglen_ff;
   logic [1:0]  in_dir_ff;
   logic        out_free;
   logic        fire;

   // the output register frees when empty or being taken this cycle
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff   <= req_tdata[7:0];
         in_seglen_ff <= req_tdata[39:8];
         in_dir_ff    <= req_tuser;
      end
   end

   // ------------------------------------------------------------------
   // parser state, one set per direction
   // ------------------------------------------------------------------
   opcua_ms_pkg::phase_type phase_ff   [opcua_ms_pkg::NUM_DIRS];
   logic [23:0]             type_ff    [opcua_ms_pkg::NUM_DIRS];
   logic [31:0]             size_ff    [opcua_ms_pkg::NUM_DIRS];
   logic [31:0]             carried_ff [opcua_ms_pkg::NUM_DIRS];
   logic [31:0]             pos_ff;
   logic                    returned_ff;

   opcua_ms_pkg::phase_type phase_in;
   logic [23:0]             type_in;
   logic [31:0]             size_in;
   logic [31:0]             carried_in;
   logic [31:0]             pos_in;
   logic                    returned_in;
   logic                    dir_write;

   opcua_ms_pkg::status_type status;
   logic [31:0] flush_point;
   logic        ev_large;
   logic        ev_bad;
   logic        ev_split;
   logic        ev_pipe;

   logic                    d;
   opcua_ms_pkg::phase_type ph;
   logic [31:0]             size_full;
   logic                    last;
   logic                    do_clear;

   assign d = in_dir_ff[0];
   assign ph = phase_ff[d];
   // the last size byte completes the word in the top lane
   assign size_full = size_ff[d] | {in_byte_ff, 24'd0};
   assign last = ({1'b0, pos_ff} + 33'd1) >= {1'b0, in_seglen_ff};

   always_comb begin
      status      = opcua_ms_pkg::ST_CONTINUE;
      flush_point = 32'd0;
      ev_large    = 1'b0;
      ev_bad      = 1'b0;
      ev_split    = 1'b0;
      ev_pipe     = 1'b0;
      phase_in    = ph;
      type_in     = type_ff[d];
      size_in     = size_ff[d];
      carried_in  = carried_ff[d];
      do_clear    = 1'b0;
      dir_write   = 1'b0;

      if (returned_ff) begin
         // segment already closed: drop the rest of it
         status = opcua_ms_pkg::ST_DROPPED;
      end else if (in_dir_ff[1]) begin
         status = opcua_ms_pkg::ST_ABORT;
      end else begin
         dir_write = 1'b1;
         case (ph)
            opcua_ms_pkg::PHASE_TYPE1: begin
               type_in  = type_ff[d] | {in_byte_ff, 16'd0};
               phase_in = opcua_ms_pkg::PHASE_TYPE2;
            end
            opcua_ms_pkg::PHASE_TYPE2: begin
               type_in  = type_ff[d] | {8'd0, in_byte_ff, 8'd0};
               phase_in = opcua_ms_pkg::PHASE_TYPE3;
            end
            opcua_ms_pkg::PHASE_TYPE3: begin
               type_in  = type_ff[d] | {16'd0, in_byte_ff};
               phase_in = opcua_ms_pkg::PHASE_FINAL;
            end
            opcua_ms_pkg::PHASE_FINAL: begin
               phase_in = opcua_ms_pkg::PHASE_SIZE1;
            end
            opcua_ms_pkg::PHASE_SIZE1: begin
               size_in  = size_ff[d] | {24'd0, in_byte_ff};
               phase_in = opcua_ms_pkg::PHASE_SIZE2;
            end
            opcua_ms_pkg::PHASE_SIZE2: begin
               size_in  = size_ff[d] | {16'd0, in_byte_ff, 8'd0};
               phase_in = opcua_ms_pkg::PHASE_SIZE3;
            end
            opcua_ms_pkg::PHASE_SIZE3: begin
               size_in  = size_ff[d] | {8'd0, in_byte_ff, 16'd0};
               phase_in = opcua_ms_pkg::PHASE_SIZE4;
            end
            opcua_ms_pkg::PHASE_SIZE4: begin
               size_in  = size_full;
               ev_large = size_full > threshold_ff;
               if (!opcua_ms_pkg::type_known(type_ff[d])) begin
                  ev_bad   = 1'b1;
                  status   = opcua_ms_pkg::ST_ABORT;
                  do_clear = 1'b1;
               end else if (size_full <= carried_ff[d]) begin
                  status   = opcua_ms_pkg::ST_ABORT;
                  do_clear = 1'b1;
               end else begin
                  phase_in = opcua_ms_pkg::PHASE_FLUSH;
               end
            end
            opcua_ms_pkg::PHASE_FLUSH: begin
               ev_split    = (carried_ff[d] != 32'd0) || (size_ff[d] > in_seglen_ff);
               ev_pipe     = size_ff[d] < in_seglen_ff;
               flush_point = size_ff[d] - carried_ff[d];
               status      = opcua_ms_pkg::ST_FLUSH;
               do_clear    = 1'b1;
            end
            default: begin
               // phase never entered: recover by aborting
               status   = opcua_ms_pkg::ST_ABORT;
               do_clear = 1'b1;
            end
         endcase

         if (do_clear) begin
            phase_in   = opcua_ms_pkg::PHASE_TYPE1;
            type_in    = 24'd0;
            size_in    = 32'd0;
            carried_in = 32'd0;
         end

         // segment ends mid-message: carry its length over
         if (status == opcua_ms_pkg::ST_CONTINUE && last) begin
            status     = opcua_ms_pkg::ST_SEARCH;
            carried_in = carried_ff[d] + in_seglen_ff;
         end
      end

      if (last) begin
         pos_in      = 32'd0;
         returned_in = 1'b0;
      end else begin
         pos_in      = pos_ff + 32'd1;
         returned_in = returned_ff || (status == opcua_ms_pkg::ST_FLUSH) ||
                       (status == opcua_ms_pkg::ST_ABORT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < opcua_ms_pkg::NUM_DIRS; i++) begin
            phase_ff[i]   <= opcua_ms_pkg::PHASE_TYPE1;
            type_ff[i]    <= 24'd0;
            size_ff[i]    <= 32'd0;
            carried_ff[i] <= 32'd0;
         end
         pos_ff      <= 32'd0;
         returned_ff <= 1'b0;
      end else if (fire) begin
         if (dir_write) begin
            phase_ff[d]   <= phase_in;
            type_ff[d]    <= type_in;
            size_ff[d]    <= size_in;
            carried_ff[d] <= carried_in;
         end
         pos_ff      <= pos_in;
         returned_ff <= returned_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (out_free) begin
         rsp_tvalid <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_tdata <= {4'd0, ev_pipe, ev_split, ev_bad, ev_large, flush_point};
         rsp_tuser <= status;
      end
   end

endmodule

>>> tb/opcua_ms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPC UA message splitter checker
// Watches the req_, rsp_ and csr_ ports, predicts one result word per
// accepted stream word and compares the rsp_ words in order, field by field.
// ----------------------------------------------------------------------------
module opcua_ms_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] segment_length
   input  logic [1:0]  req_tuser,   // [1:0] direction
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] flush_point, [32] large, [33] bad type,
                                    // [34] split, [35] pipelined
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_words,
   output int          live_words,
   output int          flush_count,
   output int          abort_count
);

   localparam logic [2:0] THRESHOLD_ADDR = {opcua_ms_pkg::REG_LARGE_SIZE_THRESHOLD, 2'b00};

   typedef struct packed {
      opcua_ms_pkg::status_type status;
      logic [31:0]              flush_point;
      logic                     large_ev;
      logic                     bad_type_ev;
      logic                     split_ev;
      logic                     pipelined_ev;
   } split_result_type;

   split_result_type owed_results[$];
   split_result_type want;

   // per-direction header parser copy
   opcua_ms_pkg::phase_type hdr_phase [opcua_ms_pkg::NUM_DIRS];
   logic [23:0]             hdr_type  [opcua_ms_pkg::NUM_DIRS];
   logic [31:0]             hdr_size  [opcua_ms_pkg::NUM_DIRS];
   logic [31:0]             carried   [opcua_ms_pkg::NUM_DIRS];
   logic [31:0]             seg_pos;
   logic                    seg_returned;
   logic [31:0]             size_threshold;

   int fails = 0;
   int lives = 0;
   int flushes = 0;
   int aborts = 0;

   function automatic logic is_opc_type(input logic [23:0] t);
      return t inside {opcua_ms_pkg::TYPE_HEL, opcua_ms_pkg::TYPE_ACK,
                       opcua_ms_pkg::TYPE_ERR, opcua_ms_pkg::TYPE_RHE,
                       opcua_ms_pkg::TYPE_OPN, opcua_ms_pkg::TYPE_MSG,
                       opcua_ms_pkg::TYPE_CLO};
   endfunction

   function automatic void clear_dir(input int d);
      hdr_phase[d] = opcua_ms_pkg::PHASE_TYPE1;
      hdr_type[d]  = '0;
      hdr_size[d]  = '0;
      carried[d]   = '0;
   endfunction

   function automatic void reset_parser();
      clear_dir(0);
      clear_dir(1);
      seg_pos        = '0;
      seg_returned   = 1'b0;
      size_threshold = opcua_ms_pkg::THRESHOLD_RESET;
   endfunction

   // advance the parser by one stream byte and return the word it owes
   function automatic split_result_type split_byte(input logic [7:0] b,
                                                   input logic [1:0] dir,
                                                   input logic [31:0] seglen);
      split_result_type        r;
      logic                    seg_last;
      opcua_ms_pkg::phase_type ph;
      int                      d;
      r        = '0;
      r.status = opcua_ms_pkg::ST_CONTINUE;
      seg_last = ({1'b0, seg_pos} + 33'd1) >= {1'b0, seglen};
      if (seg_returned) begin
         r.status = opcua_ms_pkg::ST_DROPPED;
      end else if (dir > 2'd1) begin
         r.status = opcua_ms_pkg::ST_ABORT;
      end else begin
         d  = int'(dir[0]);
         ph = hdr_phase[d];
         if (ph <= opcua_ms_pkg::PHASE_TYPE3) begin
            hdr_type[d]  = hdr_type[d] |
                           (24'(b) << (8 * (opcua_ms_pkg::PHASE_TYPE3 - ph)));
            hdr_phase[d] = ph + 4'd1;
         end else if (ph == opcua_ms_pkg::PHASE_FINAL) begin
            hdr_phase[d] = opcua_ms_pkg::PHASE_SIZE1;
         end else if (ph < opcua_ms_pkg::PHASE_SIZE4) begin
            hdr_size[d]  = hdr_size[d] |
                           (32'(b) << (8 * (ph - opcua_ms_pkg::PHASE_SIZE1)));
            hdr_phase[d] = ph + 4'd1;
         end else if (ph == opcua_ms_pkg::PHASE_SIZE4) begin
            hdr_size[d] = hdr_size[d] | {b, 24'd0};
            if (hdr_size[d] > size_threshold) r.large_ev = 1'b1;
            if (!is_opc_type(hdr_type[d])) begin
               r.bad_type_ev = 1'b1;
               r.status      = opcua_ms_pkg::ST_ABORT;
            end else if (hdr_size[d] <= carried[d]) begin
               r.status = opcua_ms_pkg::ST_ABORT;
            end else begin
               hdr_phase[d] = opcua_ms_pkg::PHASE_FLUSH;
            end
            if (r.status == opcua_ms_pkg::ST_ABORT) clear_dir(d);
         end else if (ph == opcua_ms_pkg::PHASE_FLUSH) begin
            r.split_ev     = (carried[d] != 0) || (hdr_size[d] > seglen);
            r.pipelined_ev = hdr_size[d] < seglen;
            r.flush_point  = hdr_size[d] - carried[d];
            r.status       = opcua_ms_pkg::ST_FLUSH;
            clear_dir(d);
         end else begin
            r.status = opcua_ms_pkg::ST_ABORT;
            clear_dir(d);
         end
         if (r.status == opcua_ms_pkg::ST_CONTINUE && seg_last) begin
            r.status   = opcua_ms_pkg::ST_SEARCH;
            carried[d] = carried[d] + seglen;
         end
      end
      if (r.status == opcua_ms_pkg::ST_FLUSH || r.status == opcua_ms_pkg::ST_ABORT)
         seg_returned = 1'b1;
      if (seg_last) begin
         seg_pos      = '0;
         seg_returned = 1'b0;
      end else begin
         seg_pos = seg_pos + 32'd1;
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", what, want_v, got_v);
         fails++;
      end
   endtask

   initial reset_parser();

   always @(posedge clock) begin
      if (reset) begin
         reset_parser();
         owed_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == THRESHOLD_ADDR) begin
            if (csr_pwrite) size_threshold = csr_pwdata;
            else check_field("large_size_threshold", size_threshold, csr_prdata);
         end
         if (req_tvalid && req_tready) begin
            want = split_byte(req_tdata[7:0], req_tuser, req_tdata[39:8]);
            if (want.status != opcua_ms_pkg::ST_DROPPED) lives++;
            if (want.status == opcua_ms_pkg::ST_FLUSH) flushes++;
            if (want.status == opcua_ms_pkg::ST_ABORT) aborts++;
            owed_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               $error("rsp word arrived with no result owed");
               fails++;
            end else begin
               want = owed_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("flush_point", want.flush_point, rsp_tdata[31:0]);
               check_field("large_size_event", 32'(want.large_ev), 32'(rsp_tdata[32]));
               check_field("bad_type_event", 32'(want.bad_type_ev), 32'(rsp_tdata[33]));
               check_field("split_event", 32'(want.split_ev), 32'(rsp_tdata[34]));
               check_field("pipelined_event", 32'(want.pipelined_ev), 32'(rsp_tdata[35]));
            end
         end
      end
      fail_count    <= fails;
      pending_words <= owed_results.size();
      live_words    <= lives;
      flush_count   <= flushes;
      abort_count   <= aborts;
   end

endmodule

>>> tb/tb_opcua_message_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OPC UA message splitter testbench
// Drives stream words made of OPC UA TCP headers cut into segments of random
// size, with noise and broken headers mixed in, across several handshake
// mixes and threshold settings. The checker beside the block does the
// prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_opcua_message_splitter;

   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         SETTLE_CYCLES   = 6;
   localparam int         WORDS_PER_PHASE = 432;
   localparam int         MSG_BYTES       = 9;   // eight header bytes and one body byte
   localparam logic [2:0] THRESHOLD_ADDR  = {opcua_ms_pkg::REG_LARGE_SIZE_THRESHOLD, 2'b00};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [39:0] req_tdata   = '0;    // [7:0] data_byte, [39:8] segment_length
   logic [1:0]  req_tuser   = '0;    // [1:0] direction
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;           // [31:0] flush_point, [35:32] events
   logic [2:0]  rsp_tuser;           // [2:0] status
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_words;
   int live_words;
   int flush_count;
   int abort_count;

   int          idle_pct    = 0;
   int          stall_pct   = 0;
   int          idle_cycles = 0;
   int          words_sent  = 0;
   logic [31:0] cur_threshold = opcua_ms_pkg::THRESHOLD_RESET;

   // per-direction message under construction: header then one body byte
   logic [7:0] msg_bytes [opcua_ms_pkg::NUM_DIRS][MSG_BYTES];
   int         msg_idx   [opcua_ms_pkg::NUM_DIRS] = '{MSG_BYTES, MSG_BYTES};
   bit         seg_spent;

   always #5 clock = ~clock;

   opcua_message_splitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   opcua_ms_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .live_words    (live_words),
      .flush_count   (flush_count),
      .abort_count   (abort_count)
   );

   // Receiver: decide afresh every cycle whether to stall the result channel.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: count cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one stream word, idling the sender cycle by cycle first, and hold
   // it until taken. Called at a rising edge; returns at the accepting edge.
   task automatic send_word(input logic [7:0] b, input logic [1:0] dir,
                            input logic [31:0] seglen);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {seglen, b};
      req_tuser  <= dir;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Hold the sender off until every owed result has come back, then settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register access: setup phase, access phase, then a quiet phase so
   // that back-to-back accesses never touch psel twice in one step.
   task automatic csr_access(input logic wr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= THRESHOLD_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Build the next header for one direction: mostly known types, a few
   // near misses and random garbage; sizes around the segment lengths, far
   // above them, zero, and just below, at and just above the current threshold.
   function automatic void fill_message(input int d);
      logic [23:0] kind;
      logic [31:0] size;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 86) begin
         case ($urandom_range(6))
            0:       kind = opcua_ms_pkg::TYPE_HEL;
            1:       kind = opcua_ms_pkg::TYPE_ACK;
            2:       kind = opcua_ms_pkg::TYPE_ERR;
            3:       kind = opcua_ms_pkg::TYPE_RHE;
            4:       kind = opcua_ms_pkg::TYPE_OPN;
            5:       kind = opcua_ms_pkg::TYPE_MSG;
            default: kind = opcua_ms_pkg::TYPE_CLO;
         endcase
      end else if (pick < 93) begin
         kind = opcua_ms_pkg::TYPE_MSG ^ (24'd1 << $urandom_range(23));
      end else begin
         kind = 24'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 35)      size = $urandom_range(1, 40);
      else if (pick < 65) size = $urandom_range(41, 600);
      else if (pick < 78) size = $urandom;
      else if (pick < 84) size = 32'd0;
      else if (pick < 92) size = cur_threshold + $urandom_range(2) - 32'd1;
      else                size = $urandom_range(9, 24);
      msg_bytes[d][0] = kind[23:16];
      msg_bytes[d][1] = kind[15:8];
      msg_bytes[d][2] = kind[7:0];
      msg_bytes[d][3] = ($urandom_range(3) == 0) ? 8'($urandom) : "F";
      msg_bytes[d][4] = size[7:0];
      msg_bytes[d][5] = size[15:8];
      msg_bytes[d][6] = size[23:16];
      msg_bytes[d][7] = size[31:24];
      msg_bytes[d][8] = 8'($urandom);
      msg_idx[d]      = 0;
   endfunction

   // Take the next byte of a direction's message. Once the body byte goes out
   // the block drops the rest of the segment, so mark the segment spent.
   function automatic logic [7:0] next_stream_byte(input int d);
      logic [7:0] b;
      if (msg_idx[d] >= MSG_BYTES) fill_message(d);
      b          = msg_bytes[d][msg_idx[d]];
      msg_idx[d] = msg_idx[d] + 1;
      if (msg_idx[d] == MSG_BYTES) seg_spent = 1'b1;
      return b;
   endfunction

   // One segment: a direction, a length and that many words. Headers run on
   // across segment ends, so carried bytes and split flushes come naturally.
   // Endless segments (lengths of 2^31 or more) are cut short by a final word whose
   // own length makes it the last one.
   task automatic send_segment();
      int          pick;
      int          words;
      logic [1:0]  dir;
      logic [1:0]  bdir;
      logic [31:0] seglen;
      logic [7:0]  b;
      bit          noise;
      bit          endless;
      pick    = $urandom_range(99);
      dir     = (pick < 47) ? 2'd0 : (pick < 94) ? 2'd1 : (pick < 99) ? 2'd2 : 2'd3;
      noise   = ($urandom_range(99) < 8);
      endless = 1'b0;
      pick    = $urandom_range(99);
      if (pick < 60)      seglen = $urandom_range(1, 16);
      else if (pick < 84) seglen = $urandom_range(17, 64);
      else if (pick < 88) seglen = 32'd0;
      else if (pick < 96) seglen = $urandom_range(65, 160);
      else begin
         endless = 1'b1;
         seglen  = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      end
      words     = endless ? $urandom_range(2, 12) : ((seglen == 0) ? 1 : int'(seglen));
      seg_spent = 1'b0;
      for (int i = 0; i < words; i++) begin
         bdir = dir;
         // now and then a word of the other direction inside the segment
         if (dir <= 2'd1 && $urandom_range(99) < 4) bdir = {1'b0, ~dir[0]};
         if (noise || seg_spent || bdir > 2'd1) b = 8'($urandom);
         else b = next_stream_byte(int'(bdir[0]));
         send_word(b, bdir, seglen);
      end
      if (endless) send_word(8'($urandom), dir, $urandom_range(1, words + 1));
   endtask

   // One phase: set the threshold while idle, read it back, then stream
   // segments until enough words have been sent, and drain.
   task automatic run_phase(input int idle, input int stall, input logic [31:0] thr);
      int goal;
      csr_access(1'b1, thr);
      csr_access(1'b0, 32'd0);
      cur_threshold = thr;
      idle_pct      = idle;
      stall_pct     = stall;
      goal          = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) send_segment();
      wait_idle();
   endtask

   initial begin
      logic [7:0] hel_msg [MSG_BYTES] = '{"H", "E", "L", "F", 8'd9, 8'd0, 8'd0, 8'd0, 8'hA5};
      logic [7:0] bad_hdr [8]         = '{"X", "Y", "Z", "F", 8'hFF, 8'hFF, 8'hFF, 8'hFF};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset threshold, no gaps and no stalls.
      // A whole HEL message exactly filling its segment: plain flush.
      foreach (hel_msg[i]) send_word(hel_msg[i], 2'd0, 32'd9);
      // Unknown type with an all-ones size in an endless segment: abort,
      // then a short final word that is dropped and closes the segment.
      foreach (bad_hdr[i]) send_word(bad_hdr[i], 2'd1, 32'hFFFF_FFFF);
      send_word(8'h00, 2'd1, 32'd1);
      // Unknown directions: abort then drop, and a zero length acting as one.
      send_word(8'h5A, 2'd2, 32'd2);
      send_word(8'hA5, 2'd2, 32'd2);
      send_word(8'h00, 2'd3, 32'd0);
      send_word(8'hFF, 2'd3, 32'd1);
      // A segment ending mid-header: continue, then search.
      send_word("M", 2'd0, 32'd2);
      send_word("S", 2'd0, 32'd2);

      // The sender pauses here until every result is back.
      wait_idle();

      // Random phases: no gaps, sender gaps, receiver stalls, both.
      run_phase(0, 0, 32'd0);
      run_phase(53, 0, $urandom_range(40, 600));
      run_phase(0, 53, 32'hFFFF_FFFF);
      run_phase(22, 22, $urandom);

      $display("Sent %0d words, %0d of them live (%0d flushes, %0d aborts),",
               words_sent, live_words, flush_count, abort_count);
      $display("over four handshake mixes and thresholds from zero to all ones.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
